### design/dmxtx_pkg.sv
// dmxtx_pkg: shared types, codes and fixed widths of the dmx512 multi-output transmitter
// no dependencies; imported by every module of the block but the ram

package dmxtx_pkg;

   localparam int POS_W         = 13;    // bit position within a frame
   localparam int CNT_W         = 10;    // channel count register
   localparam int TICK_W        = 16;    // tick counters and timeout
   localparam int MAP_W         = 21;    // output to universe map
   localparam int LINE_W        = 7;     // line levels field
   localparam int UNI_W         = 3;     // one map entry
   localparam int MAX_UNI       = 8;     // universes addressable by a map entry
   localparam int BYTE_W        = 8;
   localparam int SLOT_FIELD_W  = 3;
   localparam int CHAN_W        = 9;
   localparam int MODE_W        = 2;
   localparam int BITNO_W       = 4;     // bit index within a slot, 0..10
   localparam int BITS_PER_SLOT = 11;
   localparam int STOP_BIT_LAST = 10;
   localparam int FIRST_STOP    = 9;
   localparam int REQ_DATA_W    = 24;
   localparam int RSP_DATA_W    = 24;
   localparam int REQ_USER_W    = 2;
   localparam int RSP_USER_W    = 2;
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;

   localparam logic [CNT_W-1:0]  CNT_RESET     = 10'd512;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd52084;
   localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK    = 2'd0,
      MODE_WRITE   = 2'd1,
      MODE_TRIGGER = 2'd2,
      MODE_UNUSED  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_CHANNEL_COUNT = 2'd0,
      REG_SYNC_ENABLE   = 2'd1,
      REG_SYNC_TIMEOUT  = 2'd2,
      REG_SLOT_MAP      = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      LVL_LOW  = 2'd0,
      LVL_HIGH = 2'd1,
      LVL_DATA = 2'd2
   } level_kind_type;

   typedef struct packed {
      logic [CNT_W-1:0]  channel_count;
      logic              sync_enable;
      logic [TICK_W-1:0] sync_timeout;
      logic [MAP_W-1:0]  slot_map;
   } cfg_type;

   // what one tick hands from the sequencer to the line stage
   typedef struct packed {
      level_kind_type    kind;
      logic [2:0]        bit_sel;
      logic              data_zero;
      logic              frame_start;
      logic              holding;
      logic [TICK_W-1:0] last_ticks;
   } tick_info_type;

endpackage

### design/dmxtx_ram.sv
// dmxtx_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies

module dmxtx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/dmxtx_csr.sv
// dmxtx_csr: configuration registers behind the apb-style port
// depends on dmxtx_pkg

module dmxtx_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dmxtx_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [dmxtx_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [dmxtx_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready,
   output dmxtx_pkg::cfg_type               cfg
);

   import dmxtx_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr_stb;

   assign csr_pready = 1'b1;
   assign idx        = reg_index_type'(csr_paddr[3:2]);
   assign wr_stb     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_stb) begin
         case (idx)
            REG_CHANNEL_COUNT: cfg_in.channel_count = csr_pwdata[CNT_W-1:0];
            REG_SYNC_ENABLE:   cfg_in.sync_enable   = csr_pwdata[0];
            REG_SYNC_TIMEOUT:  cfg_in.sync_timeout  = csr_pwdata[TICK_W-1:0];
            REG_SLOT_MAP:      cfg_in.slot_map      = csr_pwdata[MAP_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count <= CNT_RESET;
         cfg_ff.sync_enable   <= 1'b0;
         cfg_ff.sync_timeout  <= TIMEOUT_RESET;
         cfg_ff.slot_map      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         REG_CHANNEL_COUNT: csr_prdata = CSR_DATA_W'(cfg_ff.channel_count);
         REG_SYNC_ENABLE:   csr_prdata = CSR_DATA_W'(cfg_ff.sync_enable);
         REG_SYNC_TIMEOUT:  csr_prdata = CSR_DATA_W'(cfg_ff.sync_timeout);
         REG_SLOT_MAP:      csr_prdata = CSR_DATA_W'(cfg_ff.slot_map);
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### design/dmxtx_seq.sv
// dmxtx_seq: frame sequencer - bit position, slot and bit counters, sync hold, tick counts
// depends on dmxtx_pkg; drives the universe ram read address

module dmxtx_seq #(
   parameter int SLOTS_PER_UNIVERSE    = 512,
   parameter int BREAK_BITS            = 30,
   parameter int MARK_AFTER_BREAK_BITS = 10,
   localparam int ADDR_W = (SLOTS_PER_UNIVERSE > 1) ? $clog2(SLOTS_PER_UNIVERSE) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dmxtx_pkg::cfg_type       cfg,
   input  logic                     tick_acc,
   input  logic                     trig_acc,
   output logic [ADDR_W-1:0]        rd_addr,
   output dmxtx_pkg::tick_info_type info
);

   import dmxtx_pkg::*;

   localparam int SLOT_W     = $clog2(SLOTS_PER_UNIVERSE + 2);
   localparam int DATA_START = BREAK_BITS + MARK_AFTER_BREAK_BITS;

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [BITNO_W-1:0] bitno_ff, bitno_in;
   logic               pending_ff, pending_in;
   logic [TICK_W-1:0]  ticks_ff, ticks_in;
   logic [TICK_W-1:0]  prev_ff, prev_in;

   logic [CNT_W-1:0]   eff_n;
   logic [POS_W-1:0]   frame_len;
   logic [POS_W-1:0]   pos_inc;
   logic [TICK_W-1:0]  ticks_new;
   logic               at_end;
   logic               hold;

   always_comb begin
      eff_n = cfg.channel_count;
      if (eff_n == '0) begin
         eff_n = CNT_W'(1);
      end
      if (eff_n > CNT_W'(SLOTS_PER_UNIVERSE)) begin
         eff_n = CNT_W'(SLOTS_PER_UNIVERSE);
      end
   end

   assign frame_len = (POS_W'(eff_n) + POS_W'(1)) * POS_W'(BITS_PER_SLOT) + POS_W'(DATA_START);
   assign pos_inc   = pos_ff + POS_W'(1);
   assign ticks_new = (ticks_ff == TICK_MAX) ? ticks_ff : ticks_ff + TICK_W'(1);
   assign at_end    = (pos_inc >= frame_len);
   assign hold      = at_end & cfg.sync_enable & ~pending_ff & (ticks_new < cfg.sync_timeout);

   // level class of the current bit time
   always_comb begin
      info.kind        = LVL_DATA;
      info.bit_sel     = 3'(bitno_ff - BITNO_W'(1));
      info.data_zero   = (slot_ff == '0) || (slot_ff > SLOT_W'(SLOTS_PER_UNIVERSE));
      info.frame_start = (pos_ff == '0);
      info.holding     = hold;
      info.last_ticks  = (at_end && !hold) ? ticks_new : prev_ff;
      if (pos_ff < POS_W'(BREAK_BITS)) begin
         info.kind = LVL_LOW;
      end else if (pos_ff < POS_W'(DATA_START)) begin
         info.kind = LVL_HIGH;
      end else if (bitno_ff == '0) begin
         info.kind = LVL_LOW;
      end else if (bitno_ff >= BITNO_W'(FIRST_STOP)) begin
         info.kind = LVL_HIGH;
      end
   end

   assign rd_addr = ADDR_W'(slot_ff - SLOT_W'(1));

   always_comb begin
      pos_in     = pos_ff;
      slot_in    = slot_ff;
      bitno_in   = bitno_ff;
      pending_in = pending_ff | trig_acc;
      ticks_in   = ticks_ff;
      prev_in    = prev_ff;
      if (tick_acc) begin
         ticks_in = ticks_new;
         pos_in   = pos_inc;
         if (at_end) begin
            if (hold) begin
               // park on the last stop bit of the last slot
               pos_in   = frame_len - POS_W'(1);
               slot_in  = SLOT_W'(eff_n);
               bitno_in = BITNO_W'(STOP_BIT_LAST);
            end else begin
               pos_in     = '0;
               slot_in    = '0;
               bitno_in   = '0;
               pending_in = 1'b0;
               prev_in    = ticks_new;
               ticks_in   = '0;
            end
         end else if (pos_inc == POS_W'(DATA_START)) begin
            slot_in  = '0;
            bitno_in = '0;
         end else if (pos_ff >= POS_W'(DATA_START)) begin
            if (bitno_ff == BITNO_W'(STOP_BIT_LAST)) begin
               bitno_in = '0;
               slot_in  = slot_ff + SLOT_W'(1);
            end else begin
               bitno_in = bitno_ff + BITNO_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         slot_ff    <= '0;
         bitno_ff   <= '0;
         pending_ff <= 1'b0;
         ticks_ff   <= '0;
         prev_ff    <= '0;
      end else begin
         pos_ff     <= pos_in;
         slot_ff    <= slot_in;
         bitno_ff   <= bitno_in;
         pending_ff <= pending_in;
         ticks_ff   <= ticks_in;
         prev_ff    <= prev_in;
      end
   end

endmodule

### design/dmxtx_out.sv
// dmxtx_out: line stage - turns ram bytes and tick info into line levels, output register
// depends on dmxtx_pkg

module dmxtx_out #(
   parameter int OUTPUTS = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                tick_acc,
   input  dmxtx_pkg::tick_info_type            info,
   input  logic [dmxtx_pkg::BYTE_W-1:0]        uni_bytes [dmxtx_pkg::MAX_UNI],
   input  logic [dmxtx_pkg::MAP_W-1:0]         slot_map,
   output logic                                take_ok,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dmxtx_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [dmxtx_pkg::RSP_USER_W-1:0]    rsp_tuser
);

   import dmxtx_pkg::*;

   logic          s1_valid_ff, s1_valid_in;
   tick_info_type s1_info_ff;
   logic          s1_move;
   logic [LINE_W-1:0] lv;

   logic              out_valid_ff, out_valid_in;
   logic [LINE_W-1:0] out_lv_ff;
   logic              out_start_ff;
   logic              out_hold_ff;
   logic [TICK_W-1:0] out_ticks_ff;

   assign s1_move     = s1_valid_ff & (~out_valid_ff | rsp_tready);
   assign take_ok     = ~s1_valid_ff | s1_move;
   assign s1_valid_in = tick_acc | (s1_valid_ff & ~s1_move);
   assign out_valid_in = s1_move | (out_valid_ff & ~rsp_tready);

   always_comb begin
      logic [UNI_W-1:0] sel;
      sel = '0;
      for (int i = 0; i < LINE_W; i++) begin
         lv[i] = 1'b0;
         sel   = slot_map[UNI_W*i +: UNI_W];
         if (i < OUTPUTS) begin
            case (s1_info_ff.kind)
               LVL_LOW:  lv[i] = 1'b0;
               LVL_HIGH: lv[i] = 1'b1;
               LVL_DATA: lv[i] = ~s1_info_ff.data_zero & uni_bytes[sel][s1_info_ff.bit_sel];
               default:  lv[i] = 1'b0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_acc) begin
         s1_info_ff <= info;
      end
      if (s1_move) begin
         out_lv_ff    <= lv;
         out_start_ff <= s1_info_ff.frame_start;
         out_hold_ff  <= s1_info_ff.holding;
         out_ticks_ff <= s1_info_ff.last_ticks;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_ticks_ff, out_lv_ff});
   assign rsp_tuser  = {out_hold_ff, out_start_ff};

endmodule

### design/dmx512_multi_output_transmitter.sv
// dmx512_multi_output_transmitter: top level of the seven-line dmx512 transmitter
// depends on dmxtx_pkg, dmxtx_ram, dmxtx_csr, dmxtx_seq, dmxtx_out
//
//  port group | direction | carries
//  -----------+-----------+-------------------------------------------------------
//  req_*      | in        | one request: tick, channel byte write or sync trigger
//  rsp_*      | out       | one result per tick: line levels, flags, last frame ticks
//  csr_*      | in/out    | channel count, sync enable, sync timeout, slot map
//
// a request is taken every cycle unless clearing or stalled; a tick's result passes the s1
// and output registers; the universe bytes sit in one ram per universe, all read at the same
// channel address; after reset a clearing pass writes zero through every ram, one address
// a cycle over all SLOTS_PER_UNIVERSE addresses (512 by default); requests wait, csr writes
// are taken; a stalled result holds the result stage, and the next tick waits behind it

module dmx512_multi_output_transmitter #(
   parameter int OUTPUTS               = 7,
   parameter int SLOTS_PER_UNIVERSE    = 512,
   parameter int BREAK_BITS            = 30,
   parameter int MARK_AFTER_BREAK_BITS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [dmxtx_pkg::REQ_DATA_W-1:0] req_tdata,  // slot[2:0], channel[11:3], value[19:12]
   input  logic [dmxtx_pkg::REQ_USER_W-1:0] req_tuser,  // mode[1:0]
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [dmxtx_pkg::RSP_DATA_W-1:0] rsp_tdata,  // line_levels[6:0], last_frame_ticks[22:7]
   output logic [dmxtx_pkg::RSP_USER_W-1:0] rsp_tuser,  // frame_start[0], holding[1]
   // configuration port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dmxtx_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [dmxtx_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [dmxtx_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);

   import dmxtx_pkg::*;

   localparam int ADDR_W = (SLOTS_PER_UNIVERSE > 1) ? $clog2(SLOTS_PER_UNIVERSE) : 1;

   cfg_type       cfg;
   tick_info_type info;

   // request fields
   mode_type                mode;
   logic [SLOT_FIELD_W-1:0] wr_slot;
   logic [CHAN_W-1:0]       wr_chan;
   logic [BYTE_W-1:0]       wr_value;

   logic req_acc;
   logic tick_acc;
   logic trig_acc;
   logic write_ok;
   logic take_ok;

   // clearing pass
   logic              clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] ram_waddr;
   logic [BYTE_W-1:0] ram_wdata;
   logic [BYTE_W-1:0] uni_bytes [MAX_UNI];

   assign mode     = mode_type'(req_tuser[MODE_W-1:0]);
   assign wr_slot  = req_tdata[2:0];
   assign wr_chan  = req_tdata[11:3];
   assign wr_value = req_tdata[19:12];

   assign req_tready = ~clr_busy_ff & take_ok;
   assign req_acc    = req_tvalid & req_tready;
   assign tick_acc   = req_acc & (mode == MODE_TICK);
   assign trig_acc   = req_acc & (mode == MODE_TRIGGER);

   // out-of-range writes are dropped
   assign write_ok = req_acc && (mode == MODE_WRITE)
                     && ({1'b0, wr_slot} < (SLOT_FIELD_W + 1)'(OUTPUTS))
                     && ({1'b0, wr_chan} < (CHAN_W + 1)'(SLOTS_PER_UNIVERSE));

   // clearing sweep over every ram address after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         if (clr_addr_ff == ADDR_W'(SLOTS_PER_UNIVERSE - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // ram write port is shared by the clearing pass and byte writes
   assign ram_waddr = clr_busy_ff ? clr_addr_ff : ADDR_W'(wr_chan);
   assign ram_wdata = clr_busy_ff ? '0 : wr_value;

   for (genvar g = 0; g < MAX_UNI; g++) begin : g_uni
      if (g < OUTPUTS) begin : g_ram
         dmxtx_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (SLOTS_PER_UNIVERSE)
         ) u_ram (
            .clock   (clock),
            .wr_en   (clr_busy_ff | (write_ok & (wr_slot == SLOT_FIELD_W'(g)))),
            .wr_addr (ram_waddr),
            .wr_data (ram_wdata),
            .rd_en   (tick_acc),
            .rd_addr (rd_addr),
            .rd_data (uni_bytes[g])
         );
      end else begin : g_none
         // map entries without a universe read as zero
         assign uni_bytes[g] = '0;
      end
   end

   dmxtx_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dmxtx_seq #(
      .SLOTS_PER_UNIVERSE    (SLOTS_PER_UNIVERSE),
      .BREAK_BITS            (BREAK_BITS),
      .MARK_AFTER_BREAK_BITS (MARK_AFTER_BREAK_BITS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .tick_acc (tick_acc),
      .trig_acc (trig_acc),
      .rd_addr  (rd_addr),
      .info     (info)
   );

   dmxtx_out #(
      .OUTPUTS (OUTPUTS)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .tick_acc   (tick_acc),
      .info       (info),
      .uni_bytes  (uni_bytes),
      .slot_map   (cfg.slot_map),
      .take_ok    (take_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### bench/tb_dmx512_multi_output_transmitter.sv
`timescale 1ns / 1ps
// tb_dmx512_multi_output_transmitter: self-checking bench for the seven-line dmx512 transmitter
// depends on dmxtx_pkg and the dmx512_multi_output_transmitter top level with its submodules

typedef struct packed {
   logic [6:0]  line_levels;
   logic        frame_start;
   logic        holding;
   logic [15:0] last_frame_ticks;
} line_result_type;

// tracks frame position, universe bytes and sync state, queues the line levels each tick gives
class dmx_line_tracker;
   localparam int LINES          = 7;
   localparam int UNIVERSE_SLOTS = 512;
   localparam int BREAK_LEN      = 30;
   localparam int MAB_LEN        = 10;

   logic [dmxtx_pkg::CNT_W-1:0]  chan_count;
   logic                         sync_on;
   logic [dmxtx_pkg::TICK_W-1:0] sync_timeout;
   logic [dmxtx_pkg::MAP_W-1:0]  slot_map;

   int unsigned                  position;
   logic [7:0]                   universe [LINES][UNIVERSE_SLOTS];
   logic                         trigger_seen;
   logic [dmxtx_pkg::TICK_W-1:0] frame_ticks;
   logic [dmxtx_pkg::TICK_W-1:0] prev_frame_len;

   line_result_type expected_lines[$];
   int errors, checked, held_seen, frames_seen;

   function new();
      chan_count     = dmxtx_pkg::CNT_RESET;
      sync_on        = 1'b0;
      sync_timeout   = dmxtx_pkg::TIMEOUT_RESET;
      slot_map       = '0;
      position       = 0;
      trigger_seen   = 1'b0;
      frame_ticks    = '0;
      prev_frame_len = '0;
      foreach (universe[u, c]) universe[u][c] = 8'd0;
   endfunction

   function void set_register(dmxtx_pkg::reg_index_type idx, logic [31:0] val);
      case (idx)
         dmxtx_pkg::REG_CHANNEL_COUNT: chan_count   = val[dmxtx_pkg::CNT_W-1:0];
         dmxtx_pkg::REG_SYNC_ENABLE:   sync_on      = val[0];
         dmxtx_pkg::REG_SYNC_TIMEOUT:  sync_timeout = val[dmxtx_pkg::TICK_W-1:0];
         dmxtx_pkg::REG_SLOT_MAP:      slot_map     = val[dmxtx_pkg::MAP_W-1:0];
         default: ;
      endcase
   endfunction

   // slot 0 is the start code; map entries 7 have no universe behind them
   function logic [7:0] byte_for(int line, int unsigned slot_no);
      logic [2:0] uni;
      if (slot_no == 0 || slot_no > UNIVERSE_SLOTS) return 8'd0;
      uni = slot_map[3*line +: 3];
      if (uni >= LINES) return 8'd0;
      return universe[uni][slot_no-1];
   endfunction

   function logic [6:0] levels_at(int unsigned pos);
      int unsigned rel, slot_no, bit_no;
      logic [6:0]  lv;
      logic [7:0]  b;
      lv = '0;
      if (pos < BREAK_LEN) return '0;
      if (pos < BREAK_LEN + MAB_LEN) return '1;
      rel     = pos - (BREAK_LEN + MAB_LEN);
      slot_no = rel / dmxtx_pkg::BITS_PER_SLOT;
      bit_no  = rel % dmxtx_pkg::BITS_PER_SLOT;
      if (bit_no == 0) return '0;
      if (bit_no >= dmxtx_pkg::FIRST_STOP) return '1;
      for (int i = 0; i < LINES; i++) begin
         b     = byte_for(i, slot_no);
         lv[i] = b[bit_no-1];
      end
      return lv;
   endfunction

   function void note_request(dmxtx_pkg::mode_type mode, logic [2:0] slot, logic [8:0] chan,
                              logic [7:0] value);
      line_result_type r;
      int unsigned     eff, frame_len;
      case (mode)
         dmxtx_pkg::MODE_WRITE: if (slot < LINES) universe[slot][chan] = value;
         dmxtx_pkg::MODE_TRIGGER: trigger_seen = 1'b1;
         dmxtx_pkg::MODE_TICK: begin
            r.line_levels = levels_at(position);
            r.frame_start = (position == 0);
            r.holding     = 1'b0;
            eff = chan_count;
            if (eff < 1) eff = 1;
            if (eff > UNIVERSE_SLOTS) eff = UNIVERSE_SLOTS;
            frame_len = (eff + 1) * dmxtx_pkg::BITS_PER_SLOT + BREAK_LEN + MAB_LEN;
            if (frame_ticks != dmxtx_pkg::TICK_MAX) frame_ticks++;
            position++;
            if (position >= frame_len) begin
               if (sync_on && !trigger_seen && frame_ticks < sync_timeout) begin
                  position  = frame_len - 1;
                  r.holding = 1'b1;
               end else begin
                  trigger_seen   = 1'b0;
                  position       = 0;
                  prev_frame_len = frame_ticks;
                  frame_ticks    = '0;
               end
            end
            position &= 'h1FFF;
            r.last_frame_ticks = prev_frame_len;
            expected_lines.push_back(r);
         end
         default: ;
      endcase
   endfunction

   function void flag(string what);
      errors++;
      if (errors <= 10) $display("mismatch: %s", what);
   endfunction

   function void check_result(line_result_type got);
      line_result_type want;
      checked++;
      if (got.holding) held_seen++;
      if (got.frame_start) frames_seen++;
      if (expected_lines.size() == 0) begin
         flag($sformatf("result %0d arrived with no tick waiting", checked));
         return;
      end
      want = expected_lines.pop_front();
      if (got.line_levels !== want.line_levels || got.frame_start !== want.frame_start ||
          got.holding !== want.holding || got.last_frame_ticks !== want.last_frame_ticks)
         flag($sformatf({"result %0d expected/actual: levels %h/%h start %b/%b ",
                         "hold %b/%b last ticks %0d/%0d"}, checked,
                        want.line_levels, got.line_levels, want.frame_start, got.frame_start,
                        want.holding, got.holding, want.last_frame_ticks,
                        got.last_frame_ticks));
   endfunction

   function int outstanding();
      return expected_lines.size();
   endfunction
endclass

module tb_dmx512_multi_output_transmitter;
   import dmxtx_pkg::*;

   localparam int CYCLE_LIMIT     = 3_000_000;
   localparam int SETTLE_CYCLES   = 16;      // well beyond a tick's path through the s1 and output registers
   localparam int PHASE_REQUESTS  = 190;
   localparam int LONG_HOLD_TICKS = 80;      // ticks sent in the final held-frame run
   localparam int STALL_CYCLES    = 400;
   localparam int PHASES          = 6;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [REQ_USER_W-1:0] req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   dmx_line_tracker tracker = new();

   int          send_idle = 6;     // percent of cycles the sender holds back
   int          recv_idle = 86;    // percent of cycles the receiver refuses a result
   logic        rsp_hold  = 1'b0;  // long receiver hold-off, set by the pressure process
   int unsigned cycle_count = 0;
   int unsigned requests_sent = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   dmx512_multi_output_transmitter dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // slot[2:0], channel[11:3], value[19:12]
      .req_tuser   (req_tuser),   // mode[1:0]
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // line_levels[6:0], last_frame_ticks[22:7]
      .rsp_tuser   (rsp_tuser),   // frame_start[0], holding[1]
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // receiver: random refusals, plus the long hold-off when pressure is applied
   always @(posedge clock) begin
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= recv_idle);
   end

   // result monitor: unpack the stream fields and hand them to the tracker
   always @(posedge clock) begin
      line_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.line_levels      = rsp_tdata[6:0];
         got.last_frame_ticks = rsp_tdata[22:7];
         got.frame_start      = rsp_tuser[0];
         got.holding          = rsp_tuser[1];
         tracker.check_result(got);
      end
   end

   // watchdog on total run length
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("dmx512_multi_output_transmitter test failed");
      $finish;
   end

   // offer one request, with random sender gaps, and note it once it is taken
   task automatic push_request(mode_type mode, logic [2:0] slot, logic [8:0] chan,
                               logic [7:0] value);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'b0000, value, chan, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_request(mode, slot, chan, value);
      requests_sent++;
   endtask

   // mostly ticks and byte writes to low channels, so written bytes show up on the lines;
   // the rest is triggers and unused-mode noise
   task automatic push_random(int trigger_pct, output bit counted);
      int         r;
      mode_type   m;
      logic [2:0] s;
      logic [8:0] c;
      logic [7:0] v;
      r = $urandom_range(99);
      s = 3'($urandom_range(7));
      c = ($urandom_range(3) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(7));
      v = 8'($urandom_range(255));
      if (r < 62)                    m = MODE_TICK;
      else if (r < 84)               m = MODE_WRITE;
      else if (r < 84 + trigger_pct) m = MODE_TRIGGER;
      else                           m = MODE_UNUSED;
      push_request(m, s, c, v);
      counted = !(m == MODE_UNUSED || (m == MODE_WRITE && s == 3'd7));
   endtask

   // setup then access cycle; select is released by the caller after a batch
   task automatic write_csr(reg_index_type idx, logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      tracker.set_register(idx, val);
   endtask

   task automatic apply_settings(int count, bit sync, int timeout, logic [20:0] map);
      write_csr(REG_CHANNEL_COUNT, count);
      write_csr(REG_SYNC_ENABLE, 32'(sync));
      write_csr(REG_SYNC_TIMEOUT, timeout);
      write_csr(REG_SLOT_MAP, 32'(map));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // stop offering, wait for every tick result, then let byte writes finish inside the block
   task automatic settle();
      req_tvalid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int   n;
      int   trigger_pct;
      bit   counted;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, store extremes, ignored writes and modes, early trigger
      push_request(MODE_TICK, 3'd0, 9'd0, 8'd0);
      push_request(MODE_WRITE, 3'd0, 9'd0, 8'hFF);
      push_request(MODE_WRITE, 3'd6, 9'd511, 8'hFF);
      push_request(MODE_WRITE, 3'd6, 9'd0, 8'h00);
      push_request(MODE_WRITE, 3'd1, 9'd511, 8'h00);
      push_request(MODE_WRITE, 3'd3, 9'd256, 8'hA5);
      push_request(MODE_WRITE, 3'd7, 9'd3, 8'h5A);      // no universe behind slot 7
      push_request(MODE_UNUSED, 3'd7, 9'd511, 8'hFF);   // unused mode, no result
      push_request(MODE_TRIGGER, 3'd0, 9'd0, 8'd0);     // trigger with sync still off
      repeat (12) push_request(MODE_TICK, 3'd0, 9'd0, 8'd0);
      settle();

      for (int phase = 0; phase < PHASES; phase++) begin
         // sender light / receiver heavy, then swapped, then no idling at all
         if (phase < 2) begin
            send_idle = 6;
            recv_idle = 86;
         end else if (phase < 4) begin
            send_idle = 86;
            recv_idle = 6;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         case (phase)
            0: begin
               trigger_pct = 8;
               apply_settings(2, 1'b0, 1, 21'h000000);
            end
            1: begin
               // count of zero acts as one; zero timeout never holds
               trigger_pct = 2;
               apply_settings(0, 1'b1, 0, 21'($urandom_range(21'h1FFFFF)));
            end
            2: begin
               // full timeout: frame ends wait for a trigger; every map entry without universe
               trigger_pct = 4;
               apply_settings(3, 1'b1, 65535, 21'h1FFFFF);
            end
            3: begin
               // count beyond the universe size acts as 512
               trigger_pct = 2;
               apply_settings(1023, 1'b1, $urandom_range(65535, 1),
                              21'($urandom_range(21'h1FFFFF)));
            end
            4: begin
               // previous frame is far past the new length, so it ends on the first tick
               trigger_pct = 2;
               apply_settings(4, 1'b1, 95 + $urandom_range(50),
                              21'($urandom_range(21'h1FFFFF)));
            end
            default: begin
               trigger_pct = 8;
               apply_settings(512, 1'b0, $urandom_range(65535),
                              21'($urandom_range(21'h1FFFFF)));
            end
         endcase
         if (phase == 4) begin
            // receiver holds off for a long stretch while requests keep coming
            fork
               begin
                  rsp_hold <= 1'b1;
                  repeat (STALL_CYCLES) @(posedge clock);
                  rsp_hold <= 1'b0;
               end
            join_none
         end
         n = 0;
         while (n < PHASE_REQUESTS) begin
            push_random(trigger_pct, counted);
            if (counted) n++;
         end
         settle();
      end

      // frame end held with no trigger under the longest timeout, stop level repeated
      apply_settings(1, 1'b1, 65535, 21'($urandom_range(21'h1FFFFF)));
      repeat (LONG_HOLD_TICKS) begin
         push_request(MODE_TICK, 3'($urandom_range(7)), 9'($urandom_range(511)),
                      8'($urandom_range(255)));
      end
      settle();

      $display("summary: %0d requests over %0d cycles, %0d tick results checked",
               requests_sent, cycle_count, tracker.checked);
      $display("summary: %0d frame starts, %0d held ticks, counts 0..1023, timeouts 0..65535",
               tracker.frames_seen, tracker.held_seen);
      if (tracker.errors == 0 && tracker.outstanding() == 0) begin
         $display("dmx512_multi_output_transmitter test passed");
      end else begin
         $display("dmx512_multi_output_transmitter test failed");
      end
      $finish;
   end

endmodule
